/* rtl/core/room_assignment_scheduler_core_defines.svh */
// Assertion macros shared by the scheduler checker.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ROOM_ASSIGNMENT_SCHEDULER_CORE_DEFINES_SVH
`define ROOM_ASSIGNMENT_SCHEDULER_CORE_DEFINES_SVH

// Check a property on every clock edge.
`define RASC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define RASC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/rasc_pkg.sv */
// ----------------------------------------------------------------------------
// rasc_pkg
// Shared types and constants of the room assignment scheduler.
// ----------------------------------------------------------------------------
package rasc_pkg;

  localparam int RASC_ROOMS       = 8;
  localparam int RASC_COUNT_BITS  = 16;
  localparam int RASC_TIME_W      = 48;
  localparam int RASC_IN_TIME_W   = 32;
  localparam int RASC_ROOM_OUT_W  = 3;
  localparam int RASC_CFG_W       = 4;

  localparam logic [RASC_CFG_W-1:0] RASC_NUM_ROOMS_RESET = 4'd8;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } seq_state_t;

  // Control from the sequencer to the room store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } store_ctl_t;

endpackage

/* rtl/core/rasc_room_store.sv */
// ----------------------------------------------------------------------------
// rasc_room_store
// Per-room free time and job count memories with one read and one write
// port; valid bits make never-written or cleared entries read as zero.
// ----------------------------------------------------------------------------
module rasc_room_store
  import rasc_pkg::*;
#(
  parameter int ROOMS      = RASC_ROOMS,
  parameter int COUNT_BITS = RASC_COUNT_BITS,
  localparam int IDX_W     = (ROOMS > 1) ? $clog2(ROOMS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  store_ctl_t             ctl,
  input  logic [IDX_W-1:0]       rd_addr,
  input  logic [IDX_W-1:0]       wr_addr,
  input  logic [RASC_TIME_W-1:0] wr_free,
  input  logic [COUNT_BITS-1:0]  wr_count,
  output logic [RASC_TIME_W-1:0] rd_free,
  output logic [COUNT_BITS-1:0]  rd_count
);

  logic [RASC_TIME_W-1:0] free_mem  [ROOMS];
  logic [COUNT_BITS-1:0]  count_mem [ROOMS];
  logic [ROOMS-1:0]       entry_valid;

  // Write the selected entry
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      free_mem[wr_addr]  <= wr_free;
      count_mem[wr_addr] <= wr_count;
    end
  end

  // Track written entries; clear drops them all at once
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      entry_valid <= '0;
    end else if (ctl.wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read, zero for entries not yet written
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      if (entry_valid[rd_addr]) begin
        rd_free  <= free_mem[rd_addr];
        rd_count <= count_mem[rd_addr];
      end else begin
        rd_free  <= '0;
        rd_count <= '0;
      end
    end
  end

endmodule

/* rtl/core/rasc_step_unit.sv */
// ----------------------------------------------------------------------------
// rasc_step_unit
// Shared compare step: folds one room entry into the running search for the
// first free room, the earliest-freeing room and the busiest room.
// ----------------------------------------------------------------------------
module rasc_step_unit
  import rasc_pkg::*;
#(
  parameter int ROOMS      = RASC_ROOMS,
  parameter int COUNT_BITS = RASC_COUNT_BITS,
  localparam int IDX_W     = (ROOMS > 1) ? $clog2(ROOMS) : 1
) (
  input  logic                      first,
  input  logic [RASC_IN_TIME_W-1:0] start_time,
  input  logic [RASC_TIME_W-1:0]    entry_free,
  input  logic [COUNT_BITS-1:0]     entry_count,
  input  logic [IDX_W-1:0]          entry_idx,
  input  logic                      found,
  input  logic [IDX_W-1:0]          found_idx,
  input  logic [COUNT_BITS-1:0]     found_count,
  input  logic [RASC_TIME_W-1:0]    best_free,
  input  logic [IDX_W-1:0]          best_idx,
  input  logic [COUNT_BITS-1:0]     best_count,
  input  logic [COUNT_BITS-1:0]     max_count,
  input  logic [IDX_W-1:0]          max_idx,
  output logic                      found_next,
  output logic [IDX_W-1:0]          found_idx_next,
  output logic [COUNT_BITS-1:0]     found_count_next,
  output logic [RASC_TIME_W-1:0]    best_free_next,
  output logic [IDX_W-1:0]          best_idx_next,
  output logic [COUNT_BITS-1:0]     best_count_next,
  output logic [COUNT_BITS-1:0]     max_count_next,
  output logic [IDX_W-1:0]          max_idx_next
);

  logic                  found_in;
  logic [COUNT_BITS-1:0] max_in;
  logic [IDX_W-1:0]      max_idx_in;
  logic                  free_ok;

  always_comb begin
    // Start a fresh search on the first room
    found_in   = first ? 1'b0 : found;
    max_in     = first ? '0 : max_count;
    max_idx_in = first ? '0 : max_idx;
    free_ok    = entry_free <= RASC_TIME_W'(start_time);

    // Lowest room free at the start time
    found_next       = found_in;
    found_idx_next   = found_idx;
    found_count_next = found_count;
    if (!found_in && free_ok) begin
      found_next       = 1'b1;
      found_idx_next   = entry_idx;
      found_count_next = entry_count;
    end

    // Earliest free room, lower room on ties
    best_free_next  = best_free;
    best_idx_next   = best_idx;
    best_count_next = best_count;
    if (first || entry_free < best_free) begin
      best_free_next  = entry_free;
      best_idx_next   = entry_idx;
      best_count_next = entry_count;
    end

    // Highest job count, lower room on ties
    max_count_next = max_in;
    max_idx_next   = max_idx_in;
    if (entry_count > max_in) begin
      max_count_next = entry_count;
      max_idx_next   = entry_idx;
    end
  end

endmodule

/* rtl/core/room_assignment_scheduler_core.sv */
// ----------------------------------------------------------------------------
// room_assignment_scheduler_core
// Assigns each job to a room and reports its actual start and end times.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries start_time, end_time and
//   last_job. Jobs must come in nondecreasing (start, end) order; a job out
//   of order or with end before start is still scheduled and flagged.
//   Output channel (out_valid/out_stall) carries one result per job.
//   cfg_wr_en/cfg_wr_data write num_rooms (0 acts as 1, above ROOMS acts as
//   ROOMS); write it only while no job is in flight.
// Timing:
//   The room scan reads one memory entry per cycle through a single compare
//   step, over the N rooms in use; a new job is taken only once the result
//   of the last one is loaded.
//   in_stall is high from acceptance until the result is loaded.
// Stall:
//   A result waits in the output register while out_stall is high; the
//   next job may be accepted meanwhile but holds before loading its result.
// Reset:
//   Clears all room state, the previous job and sets num_rooms to 8. The
//   result of the last job of a batch also clears room state.
// ----------------------------------------------------------------------------
module room_assignment_scheduler_core
  import rasc_pkg::*;
#(
  parameter int ROOMS      = RASC_ROOMS,
  parameter int COUNT_BITS = RASC_COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [RASC_CFG_W-1:0]      cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [RASC_IN_TIME_W-1:0]  start_time,
  input  logic [RASC_IN_TIME_W-1:0]  end_time,
  input  logic                       last_job,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [RASC_ROOM_OUT_W-1:0] room,
  output logic [RASC_TIME_W-1:0]     actual_start,
  output logic [RASC_TIME_W-1:0]     actual_end,
  output logic                       was_delayed,
  output logic                       order_error,
  output logic [RASC_ROOM_OUT_W-1:0] busiest_room,
  output logic                       batch_done
);

  localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int CNT_W = $clog2(ROOMS + 1);

  seq_state_t state, state_next;
  store_ctl_t ctl;

  logic [RASC_CFG_W-1:0]     num_rooms;
  logic [CNT_W-1:0]          nr;
  logic [7:0]                nr_wide;
  logic [RASC_IN_TIME_W-1:0] job_start;
  logic [RASC_IN_TIME_W-1:0] job_dur;
  logic                      job_last;
  logic                      job_err;
  logic [RASC_IN_TIME_W-1:0] prev_start;
  logic [RASC_IN_TIME_W-1:0] prev_end;

  logic [CNT_W-1:0] issue_idx;
  logic             rd_vld;
  logic [CNT_W-1:0] rd_at;
  logic             scan_done;

  logic [RASC_TIME_W-1:0] rd_free;
  logic [COUNT_BITS-1:0]  rd_count;

  logic                   found, found_next;
  logic [IDX_W-1:0]       found_idx, found_idx_next;
  logic [COUNT_BITS-1:0]  found_count, found_count_next;
  logic [RASC_TIME_W-1:0] best_free, best_free_next;
  logic [IDX_W-1:0]       best_idx, best_idx_next;
  logic [COUNT_BITS-1:0]  best_count, best_count_next;
  logic [COUNT_BITS-1:0]  max_count, max_count_next;
  logic [IDX_W-1:0]       max_idx, max_idx_next;

  logic                   in_take;
  logic                   can_load;
  logic                   finish;
  logic [IDX_W-1:0]       sel_room;
  logic [RASC_TIME_W-1:0] sel_start;
  logic [COUNT_BITS-1:0]  sel_count;
  logic [COUNT_BITS-1:0]  new_count;
  logic [RASC_TIME_W:0]   end_sum;
  logic [RASC_TIME_W-1:0] sel_end;
  logic [IDX_W-1:0]       busiest;
  logic                   in_err;
  logic [RASC_IN_TIME_W-1:0] in_dur;

  // Hold the room count register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rooms <= RASC_NUM_ROOMS_RESET;
    end else if (cfg_wr_en) begin
      num_rooms <= cfg_wr_data;
    end
  end

  // Clamp the room count into 1 .. ROOMS
  always_comb begin
    nr_wide = 8'(num_rooms);
    if (nr_wide == 8'd0) begin
      nr_wide = 8'd1;
    end else if (nr_wide > 8'(ROOMS)) begin
      nr_wide = 8'(ROOMS);
    end
  end

  // Check order and take the duration at acceptance
  always_comb begin
    in_err = (end_time < start_time) || (start_time < prev_start) ||
             ((start_time == prev_start) && (end_time < prev_end));
    in_dur = (end_time >= start_time) ? (end_time - start_time) : '0;
  end

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign scan_done = rd_vld && (rd_at == nr - 1'b1);
  assign can_load  = !out_valid || !out_stall;
  assign finish    = (state == ST_UPDATE) && can_load;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and store control
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.rd_en = (issue_idx < nr);
        if (scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (can_load) begin
          ctl.wr_en  = !job_last;
          ctl.clear  = job_last;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Capture the job
  always_ff @(posedge clk) begin
    if (in_take) begin
      job_start <= start_time;
      job_dur   <= in_dur;
      job_last  <= last_job;
      job_err   <= in_err;
      nr        <= CNT_W'(nr_wide);
    end
  end

  // Track the previous job; drop it at batch end
  always_ff @(posedge clk) begin
    if (rst || (finish && job_last)) begin
      prev_start <= '0;
      prev_end   <= '0;
    end else if (in_take) begin
      prev_start <= start_time;
      prev_end   <= end_time;
    end
  end

  // Advance the scan address and its read-data tag
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_idx <= '0;
      rd_vld    <= 1'b0;
      rd_at     <= '0;
    end else begin
      rd_vld <= ctl.rd_en;
      rd_at  <= issue_idx;
      if (in_take) begin
        issue_idx <= '0;
      end else if (ctl.rd_en) begin
        issue_idx <= issue_idx + 1'b1;
      end
    end
  end

  rasc_room_store #(
    .ROOMS      (ROOMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_addr  (issue_idx[IDX_W-1:0]),
    .wr_addr  (sel_room),
    .wr_free  (sel_end),
    .wr_count (new_count),
    .rd_free  (rd_free),
    .rd_count (rd_count)
  );

  rasc_step_unit #(
    .ROOMS      (ROOMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .first            (rd_at == '0),
    .start_time       (job_start),
    .entry_free       (rd_free),
    .entry_count      (rd_count),
    .entry_idx        (rd_at[IDX_W-1:0]),
    .found            (found),
    .found_idx        (found_idx),
    .found_count      (found_count),
    .best_free        (best_free),
    .best_idx         (best_idx),
    .best_count       (best_count),
    .max_count        (max_count),
    .max_idx          (max_idx),
    .found_next       (found_next),
    .found_idx_next   (found_idx_next),
    .found_count_next (found_count_next),
    .best_free_next   (best_free_next),
    .best_idx_next    (best_idx_next),
    .best_count_next  (best_count_next),
    .max_count_next   (max_count_next),
    .max_idx_next     (max_idx_next)
  );

  // Fold each returned entry into the search
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      found       <= found_next;
      found_idx   <= found_idx_next;
      found_count <= found_count_next;
      best_free   <= best_free_next;
      best_idx    <= best_idx_next;
      best_count  <= best_count_next;
      max_count   <= max_count_next;
      max_idx     <= max_idx_next;
    end
  end

  // Pick the room, saturate the end time and count, settle the busiest room
  always_comb begin
    sel_room  = found ? found_idx : best_idx;
    sel_start = found ? RASC_TIME_W'(job_start) : best_free;
    sel_count = found ? found_count : best_count;
    end_sum   = {1'b0, sel_start} + (RASC_TIME_W + 1)'(job_dur);
    sel_end   = end_sum[RASC_TIME_W] ? '1 : end_sum[RASC_TIME_W-1:0];
    new_count = (&sel_count) ? sel_count : sel_count + 1'b1;
    busiest   = max_idx;
    if ((new_count > max_count) ||
        ((new_count == max_count) && (sel_room < max_idx))) begin
      busiest = sel_room;
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      room         <= RASC_ROOM_OUT_W'(sel_room);
      actual_start <= sel_start;
      actual_end   <= sel_end;
      was_delayed  <= !found;
      order_error  <= job_err;
      busiest_room <= job_last ? RASC_ROOM_OUT_W'(busiest) : '0;
      batch_done   <= job_last;
    end
  end

endmodule

/* rtl/core/rasc_checker.sv */
// ----------------------------------------------------------------------------
// rasc_checker
// Port-level checks of the room assignment scheduler, bound to the top.
// ----------------------------------------------------------------------------
`include "room_assignment_scheduler_core_defines.svh"

module rasc_checker
  import rasc_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [RASC_TIME_W-1:0]     actual_start,
  input logic [RASC_TIME_W-1:0]     actual_end,
  input logic [RASC_ROOM_OUT_W-1:0] busiest_room,
  input logic                       batch_done
);

  // An accepted item blocks the input while it is scanned
  `RASC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input open after accept")

  // The busiest room is reported only at batch end
  `RASC_ASSERT(a_busiest_idle, (out_valid && !batch_done) |-> (busiest_room == '0), "busiest set mid-batch")

  // A job never ends before it starts
  `RASC_ASSERT(a_end_order, out_valid |-> (actual_end >= actual_start), "end before start")

  // A stalled result stays put
  `RASC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(actual_end), "stalled result changed")

endmodule

bind room_assignment_scheduler_core rasc_checker u_rasc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .actual_start (actual_start),
  .actual_end   (actual_end),
  .busiest_room (busiest_room),
  .batch_done   (batch_done)
);
